// ===== rtl/text_escape_crlf_encoder_macros.svh =====
// assertion macros used by the encoder serialiser
`ifndef TEXT_ESCAPE_CRLF_ENCODER_MACROS_SVH
`define TEXT_ESCAPE_CRLF_ENCODER_MACROS_SVH

// condition implies consequence in the same cycle
`define TECE_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tece assertion failed");

// condition implies consequence in the next cycle
`define TECE_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("tece assertion failed");

`endif

// ===== rtl/tece_pkg.sv =====
// types, constants and helper functions for the text escape encoder
package tece_pkg;

    localparam logic [7:0]  CHAR_CR        = 8'h0D;
    localparam logic [7:0]  CHAR_LF        = 8'h0A;
    localparam logic [7:0]  CHAR_TAB       = 8'h09;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [7:0]  CHAR_TILDE     = 8'h7E;
    localparam logic [7:0]  CHAR_CARET     = 8'h5E;
    localparam logic [7:0]  CHAR_BSLASH    = 8'h5C;
    localparam logic [7:0]  CHAR_X         = 8'h78;
    localparam logic [7:0]  CHAR_ZERO      = 8'h30;
    localparam logic [7:0]  HEX_ALPHA_BASE = 8'h37;
    localparam logic [7:0]  CARET_OFFSET   = 8'h40;
    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

    localparam int          ADDR_W         = 3;
    localparam logic        REG_PASS_LOW   = 1'b0;
    localparam logic        REG_PASS_TOP   = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       restart;
    } tece_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        run_last;
        logic        chunk_done;
        logic [31:0] byte_total;
        logic [31:0] line_total;
    } tece_out_t;

    typedef struct packed {
        logic [7:0] pass_low;
        logic [7:0] pass_top;
    } tece_cfg_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            is_lf;
    } tece_seq_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        return (nib < 4'd10) ? (CHAR_ZERO + wide) : (HEX_ALPHA_BASE + wide);
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/tece_apb_regs.sv =====
// apb register file holding the pass range
module tece_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tece_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tece_pkg::tece_cfg_t           cfg
);
    import tece_pkg::*;

    logic [7:0] pass_low_reg;
    logic [7:0] pass_top_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_low_reg <= 8'd0;
            pass_top_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_PASS_LOW: pass_low_reg <= pwdata[7:0];
                REG_PASS_TOP: pass_top_reg <= pwdata[7:0];
                default:      pass_low_reg <= pass_low_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PASS_LOW: prdata = {24'd0, pass_low_reg};
            REG_PASS_TOP: prdata = {24'd0, pass_top_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.pass_low = pass_low_reg;
    assign cfg.pass_top = pass_top_reg;

    logic unused_ok;
    assign unused_ok = ^{paddr[1:0], pwdata[31:8]};

endmodule

// ===== rtl/tece_classify.sv =====
// maps one raw byte to its escaped byte sequence
module tece_classify (
    input  logic [7:0]          data_byte,
    input  tece_pkg::tece_cfg_t cfg,
    output tece_pkg::tece_seq_t seq
);
    import tece_pkg::*;

    always_comb
    begin
        seq = '0;
        if (data_byte == CHAR_LF)
        begin
            seq.bytes[0] = CHAR_CR;
            seq.bytes[1] = CHAR_LF;
            seq.last_idx = 2'd1;
            seq.is_lf    = 1'b1;
        end
        else if ((data_byte >= CHAR_SPACE && data_byte <= CHAR_TILDE) ||
                 data_byte == CHAR_TAB)
        begin
            seq.bytes[0] = data_byte;
        end
        else if (data_byte < CHAR_SPACE)
        begin
            seq.bytes[0] = CHAR_CARET;
            seq.bytes[1] = data_byte + CARET_OFFSET;
            seq.last_idx = 2'd1;
        end
        else if (data_byte >= cfg.pass_low && data_byte <= cfg.pass_top)
        begin
            seq.bytes[0] = data_byte;
        end
        else
        begin
            seq.bytes[0] = CHAR_BSLASH;
            seq.bytes[1] = CHAR_X;
            seq.bytes[2] = hex_digit(data_byte[7:4]);
            seq.bytes[3] = hex_digit(data_byte[3:0]);
            seq.last_idx = 2'd3;
        end
    end

endmodule

// ===== rtl/tece_serialiser.sv =====
// holds one escaped sequence and sends it out a byte per beat with running counts
`include "text_escape_crlf_encoder_macros.svh"

module tece_serialiser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tece_pkg::tece_seq_t  in_seq,
    input  logic                 in_chunk_end,
    input  logic                 in_restart,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tece_pkg::tece_out_t  out_data
);
    import tece_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    tece_seq_t   seq_reg, seq_next;
    logic [1:0]  idx_reg, idx_next;
    logic        chunk_end_reg, chunk_end_next;
    logic        restart_reg, restart_next;
    logic        out_valid_reg, out_valid_next;
    tece_out_t   out_reg, out_next;
    logic [31:0] emitted_reg, emitted_next;
    logic [31:0] lines_reg, lines_next;

    logic        out_free;
    logic        byte_move;
    logic        last_byte;
    logic        first_byte;
    logic        in_take;
    logic [31:0] base_emitted;
    logic [31:0] base_lines;

    assign out_free   = !out_valid_reg || !out_stall;
    assign byte_move  = s1_valid_reg && out_free;
    assign last_byte  = (idx_reg == seq_reg.last_idx);
    assign first_byte = (idx_reg == 2'd0);
    assign in_stall   = s1_valid_reg && !(byte_move && last_byte);
    assign in_take    = in_valid && !in_stall;

    // counters clear on the first byte of a restart item
    always_comb
    begin
        base_emitted = (first_byte && restart_reg) ? 32'd0 : emitted_reg;
        base_lines   = (first_byte && restart_reg) ? 32'd0 : lines_reg;
        emitted_next = emitted_reg;
        lines_next   = lines_reg;
        if (byte_move)
        begin
            emitted_next = sat_inc(base_emitted);
            lines_next   = (first_byte && seq_reg.is_lf) ? sat_inc(base_lines) : base_lines;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        seq_next       = seq_reg;
        idx_next       = idx_reg;
        chunk_end_next = chunk_end_reg;
        restart_next   = restart_reg;
        if (in_take)
        begin
            s1_valid_next  = 1'b1;
            seq_next       = in_seq;
            idx_next       = 2'd0;
            chunk_end_next = in_chunk_end;
            restart_next   = in_restart;
        end
        else if (byte_move && last_byte)
        begin
            s1_valid_next = 1'b0;
        end
        else if (byte_move)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (byte_move)
        begin
            out_valid_next      = 1'b1;
            out_next.out_byte   = seq_reg.bytes[idx_reg];
            out_next.run_last   = last_byte;
            out_next.chunk_done = last_byte && chunk_end_reg;
            out_next.byte_total = emitted_next;
            out_next.line_total = lines_next;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            emitted_reg   <= 32'd0;
            lines_reg     <= 32'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            emitted_reg   <= emitted_next;
            lines_reg     <= lines_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg       <= seq_next;
        chunk_end_reg <= chunk_end_next;
        restart_reg   <= restart_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a beat that is not the last of its run leaves the rest of the run held
    `TECE_ASSERT_IMPL(a_run_held, clk, rst_n, out_valid_reg && !out_reg.run_last, s1_valid_reg)
    // later bytes of a run count up by one unless saturated
    `TECE_ASSERT_NEXT(a_count_step, clk, rst_n,
        byte_move && !first_byte && emitted_reg != COUNT_MAX,
        emitted_reg == $past(emitted_reg) + 32'd1)
    // the line count is the same on every beat of one run
    `TECE_ASSERT_NEXT(a_lines_steady, clk, rst_n,
        byte_move && !first_byte,
        out_reg.line_total == $past(out_reg.line_total))

endmodule

// ===== rtl/text_escape_crlf_encoder.sv =====
// top level of the text escape encoder with cr lf conversion
// Each input beat carries one text byte and yields one to four output beats: one
// for plain and passed bytes, two for line feeds and caret escapes, four for hex
// escapes. The serialiser sets the pace: it holds one escaped sequence and moves
// one byte a cycle into the output register while out_stall is low; the next
// input beat is taken in the cycle that the last byte of the current run moves
// on, so unstalled single-byte items flow at one per cycle. The pass range
// registers sit at byte addresses 0 and 4.
module text_escape_crlf_encoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tece_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tece_pkg::tece_in_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tece_pkg::tece_out_t          out_data
);
    import tece_pkg::*;

    tece_cfg_t cfg;
    tece_seq_t seq;

    tece_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tece_classify u_classify (
        .data_byte (in_data.data_byte),
        .cfg       (cfg),
        .seq       (seq)
    );

    tece_serialiser u_serialiser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_seq       (seq),
        .in_chunk_end (in_data.chunk_end),
        .in_restart   (in_data.restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
